[rtl/core/page_framebuffer_blitter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the page frame buffer blitter
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_BLITTER_TOP_ASSERT_SVH
`define PAGE_FRAMEBUFFER_BLITTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfb assertion failed");

`endif

[rtl/core/pfb_pkg.sv]
// ----------------------------------------------------------------------------
// Page frame buffer blitter package
// Types, codes and constants shared by the front end, queue and engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

    localparam int SCREEN_COLUMNS_DEF = 128;
    localparam int SCREEN_PAGES_DEF   = 8;

    localparam int X_W    = 9;
    localparam int ROW_W  = 8;
    localparam int PAGE_W = 4;
    localparam int WIDE_W = 128;

    localparam logic [2:0] OP_FILL   = 3'd0;
    localparam logic [2:0] OP_INVERT = 3'd1;
    localparam logic [2:0] OP_COLUMN = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam int COLUMN_MAX = 64;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  x_start;
        logic [5:0]  y_start;
        logic [7:0]  x_end;
        logic [6:0]  y_end;
        logic [7:0]  fill_pattern;
        logic [63:0] column_bits;
        logic [6:0]  column_height;
        logic        invert_column;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } out_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_XOR,
        CMD_READ,
        CMD_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               status;
        logic [X_W-1:0]     x0;
        logic [X_W-1:0]     x1;
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   row1;
        logic [PAGE_W-1:0]  p0;
        logic [PAGE_W-1:0]  p1;
        logic [WIDE_W-1:0]  wide;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RUN,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/pfb_front.sv]
// ----------------------------------------------------------------------------
// Blitter front end
// Accepts operations, clips and classifies them into engine commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_front #(
    parameter int SCREEN_COLUMNS = pfb_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_PAGES   = pfb_pkg::SCREEN_PAGES_DEF
) (
    input  wire logic          push,
    output logic               full,
    input  wire pfb_pkg::in_t  item,
    output logic               q_push,
    input  wire logic          q_full,
    output pfb_pkg::cmd_t      cmd
);

    localparam int ROWS = SCREEN_PAGES * 8;

    logic [15:0]  pat_two;
    logic [7:0]   pat_rot;
    logic [63:0]  col_src;
    logic [191:0] col_shift;
    logic [6:0]   height;
    int           xe_c;
    int           ye_c;
    int           ce;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        pat_two   = {item.fill_pattern, item.fill_pattern} << item.y_start[2:0];
        pat_rot   = pat_two[15:8];
        col_src   = item.invert_column ? ~item.column_bits : item.column_bits;
        col_shift = {128'd0, col_src} << item.y_start;
        height    = (item.column_height > 7'(pfb_pkg::COLUMN_MAX)) ?
                    7'(pfb_pkg::COLUMN_MAX) : item.column_height;
        xe_c = (int'(item.x_end) > SCREEN_COLUMNS) ? SCREEN_COLUMNS : int'(item.x_end);
        ye_c = (int'(item.y_end) > ROWS) ? ROWS : int'(item.y_end);
        ce   = (int'(item.y_start) + int'(height) > ROWS) ? ROWS :
               int'(item.y_start) + int'(height);

        cmd        = '0;
        cmd.kind   = pfb_pkg::CMD_NOP;
        cmd.x0     = pfb_pkg::X_W'(item.x_start);
        cmd.row0   = pfb_pkg::ROW_W'(item.y_start);
        cmd.p0     = pfb_pkg::PAGE_W'(item.y_start[5:3]);

        case (item.opcode)
            pfb_pkg::OP_FILL, pfb_pkg::OP_INVERT:
            begin
                if (item.x_end <= {1'b0, item.x_start} || item.y_end <= {1'b0, item.y_start})
                begin
                    cmd.status = 1'b1;
                end
                else if (int'(item.x_start) < SCREEN_COLUMNS && int'(item.y_start) < ROWS)
                begin
                    cmd.kind = (item.opcode == pfb_pkg::OP_FILL) ?
                               pfb_pkg::CMD_WRITE : pfb_pkg::CMD_XOR;
                    cmd.x1   = pfb_pkg::X_W'(xe_c);
                    cmd.row1 = pfb_pkg::ROW_W'(ye_c);
                    cmd.p1   = pfb_pkg::PAGE_W'((ye_c - 1) / 8);
                    cmd.wide = {(pfb_pkg::WIDE_W / 8){pat_rot}};
                end
            end
            pfb_pkg::OP_COLUMN:
            begin
                if (height != 7'd0 && int'(item.x_start) < SCREEN_COLUMNS &&
                    int'(item.y_start) < ROWS)
                begin
                    cmd.kind = pfb_pkg::CMD_WRITE;
                    cmd.x1   = pfb_pkg::X_W'(int'(item.x_start) + 1);
                    cmd.row1 = pfb_pkg::ROW_W'(ce);
                    cmd.p1   = pfb_pkg::PAGE_W'((ce - 1) / 8);
                    cmd.wide = col_shift[pfb_pkg::WIDE_W-1:0];
                end
            end
            pfb_pkg::OP_READ:
            begin
                if (int'(item.x_start) < SCREEN_COLUMNS &&
                    int'(item.y_start[5:3]) < SCREEN_PAGES)
                begin
                    cmd.kind = pfb_pkg::CMD_READ;
                end
            end
            pfb_pkg::OP_CLEAR:
            begin
                cmd.kind = pfb_pkg::CMD_CLEAR;
            end
            default:
            begin
                cmd.kind = pfb_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/pfb_cmd_queue.sv]
// ----------------------------------------------------------------------------
// Blitter command queue
// Two-entry queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_push,
    input  wire pfb_pkg::cmd_t  q_in,
    output logic                q_full,
    output logic                q_valid,
    input  wire logic           q_pop,
    output pfb_pkg::cmd_t       q_out
);

    pfb_pkg::cmd_t entry_reg [2];
    logic          wp_reg;
    logic          wp_next;
    logic          rp_reg;
    logic          rp_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_out   = entry_reg[rp_reg];

    always_comb
    begin
        wp_next  = q_push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(q_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            entry_reg[wp_reg] <= q_in;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pfb_engine.sv]
// ----------------------------------------------------------------------------
// Blitter engine
// Holds the frame store and carries out commands one page byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_framebuffer_blitter_top_assert.svh"

module pfb_engine #(
    parameter int SCREEN_COLUMNS = pfb_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_PAGES   = pfb_pkg::SCREEN_PAGES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire pfb_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output pfb_pkg::out_t       result
);

    localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]              mem [DEPTH];

    pfb_pkg::state_t         state_reg;
    pfb_pkg::state_t         state_next;
    pfb_pkg::cmd_t           cur_reg;
    pfb_pkg::cmd_t           cur_next;
    logic [pfb_pkg::PAGE_W-1:0] page_reg;
    logic [pfb_pkg::PAGE_W-1:0] page_next;
    logic [pfb_pkg::X_W-1:0] x_reg;
    logic [pfb_pkg::X_W-1:0] x_next;
    logic [AW-1:0]           clr_reg;
    logic [AW-1:0]           clr_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    pfb_pkg::out_t           out_reg;
    pfb_pkg::out_t           out_next;
    pfb_pkg::out_t           pend_reg;
    pfb_pkg::out_t           pend_next;

    logic                    wr_pend_reg;
    logic [AW-1:0]           wr_addr_reg;
    logic [7:0]              wr_mask_reg;
    logic [7:0]              wr_data_reg;
    logic                    wr_xor_reg;

    logic [7:0]              rd_q;
    logic                    re;
    logic [AW-1:0]           ra;
    logic                    issue;
    logic                    we;
    logic [AW-1:0]           wa;
    logic [7:0]              wd;
    logic [7:0]              mask;
    logic [6:0]              row;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            row     = {page_reg[3:0], 3'(b)};
            mask[b] = ({1'b0, row} >= cur_reg.row0) && ({1'b0, row} < cur_reg.row1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        page_next      = page_reg;
        x_next         = x_reg;
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        re             = 1'b0;
        issue          = 1'b0;
        ra             = AW'(int'(page_reg) * SCREEN_COLUMNS + int'(x_reg));

        case (state_reg)
            pfb_pkg::ST_INIT, pfb_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == pfb_pkg::ST_INIT) ?
                                 pfb_pkg::ST_IDLE : pfb_pkg::ST_RESULT;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            pfb_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    cur_next  = cmd;
                    page_next = cmd.p0;
                    x_next    = cmd.x0;
                    pend_next = '0;
                    case (cmd.kind)
                        pfb_pkg::CMD_WRITE, pfb_pkg::CMD_XOR:
                        begin
                            state_next = pfb_pkg::ST_RUN;
                        end
                        pfb_pkg::CMD_READ:
                        begin
                            re         = 1'b1;
                            ra         = AW'(int'(cmd.p0) * SCREEN_COLUMNS + int'(cmd.x0));
                            state_next = pfb_pkg::ST_READ_WAIT;
                        end
                        pfb_pkg::CMD_CLEAR:
                        begin
                            state_next = pfb_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            pend_next.status = cmd.status;
                            state_next       = pfb_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            pfb_pkg::ST_RUN:
            begin
                re    = 1'b1;
                issue = 1'b1;
                if (x_reg + pfb_pkg::X_W'(1) == cur_reg.x1)
                begin
                    x_next = cur_reg.x0;
                    if (page_reg == cur_reg.p1)
                    begin
                        state_next = pfb_pkg::ST_RESULT;
                    end
                    else
                    begin
                        page_next = page_reg + pfb_pkg::PAGE_W'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + pfb_pkg::X_W'(1);
                end
            end
            pfb_pkg::ST_READ_WAIT:
            begin
                pend_next.read_data = rd_q;
                state_next          = pfb_pkg::ST_RESULT;
            end
            pfb_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = pfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == pfb_pkg::ST_INIT || state_reg == pfb_pkg::ST_CLEAR)
        begin
            we = 1'b1;
            wa = clr_reg;
            wd = 8'd0;
        end
        else
        begin
            we = wr_pend_reg;
            wa = wr_addr_reg;
            wd = wr_xor_reg ? (rd_q ^ wr_mask_reg) :
                 ((rd_q & (wr_mask_reg ^ pfb_pkg::BYTE_ONES)) | (wr_data_reg & wr_mask_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_q <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfb_pkg::ST_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            wr_pend_reg   <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        page_reg    <= page_next;
        x_reg       <= x_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        wr_addr_reg <= ra;
        wr_mask_reg <= mask;
        wr_data_reg <= cur_reg.wide[{page_reg, 3'b000} +: 8];
        wr_xor_reg  <= (cur_reg.kind == pfb_pkg::CMD_XOR);
    end

    `PFB_ASSERT_SAME(a_no_rw_same_addr, clk, rst_n, we && re, wa != ra)
    `PFB_ASSERT_SAME(a_no_pop_in_sweep, clk, rst_n,
        state_reg == pfb_pkg::ST_INIT || state_reg == pfb_pkg::ST_CLEAR, !cmd_pop)
    `PFB_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !pop,
        out_valid_reg && $stable(out_reg))
    `PFB_ASSERT_NEXT(a_write_follows_issue, clk, rst_n, issue, we && !re ||
        state_reg == pfb_pkg::ST_RUN)

endmodule

`default_nettype wire

[rtl/core/page_framebuffer_blitter_top.sv]
// ----------------------------------------------------------------------------
// Page frame buffer blitter
// Monochrome page frame store with fill, invert, column write, read and clear.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        item   (pfb_pkg::in_t)
//  result    pop / empty        result (pfb_pkg::out_t)
//
// A rectangle or column transaction walks each page byte it touches in turn through the
// single read-modify-write path of the frame store. A read passes a read-wait state and
// an empty or clipped-away one goes straight to the result. Clear sweeps the store one
// byte a cycle over all SCREEN_COLUMNS * SCREEN_PAGES bytes; reset runs the same sweep,
// during which the two-entry command queue takes two transactions and then raises full.
// A result left waiting on pop holds the engine, then the queue, then the input.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_blitter_top #(
    parameter int SCREEN_COLUMNS = pfb_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_PAGES   = pfb_pkg::SCREEN_PAGES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire pfb_pkg::in_t  item,
    output logic               empty,
    input  wire logic          pop,
    output pfb_pkg::out_t      result
);

    logic          q_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    pfb_pkg::cmd_t q_in;
    pfb_pkg::cmd_t q_out;

    pfb_front #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_PAGES(SCREEN_PAGES)
    ) u_front (
        .push(push),
        .full(full),
        .item(item),
        .q_push(q_push),
        .q_full(q_full),
        .cmd(q_in)
    );

    pfb_cmd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .q_push(q_push),
        .q_in(q_in),
        .q_full(q_full),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_out(q_out)
    );

    pfb_engine #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_PAGES(SCREEN_PAGES)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(q_valid),
        .cmd(q_out),
        .cmd_pop(q_pop),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

endmodule

`default_nettype wire
